// File: hdl/slist_pkg.sv
// ----------------------------------------------------------------------------
// slist_pkg: shared types and constants of the sorted insertion list
// Capacity, field widths, opcode and status codes, request and result types.
// ----------------------------------------------------------------------------
package slist_pkg;

    localparam int CAPACITY    = 16;
    localparam int CNT_W       = $clog2(CAPACITY + 1);

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NO_MATCH = 2'd2;
    localparam logic [1:0] ST_BAD_POS  = 2'd3;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] value;
        logic [3:0]         position;
    } req_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [4:0]         entry_count;
        logic [1:0]         status;
    } rsp_t;

    typedef struct packed {
        logic               insert;
        logic               remove;
        logic signed [31:0] value;
    } cell_ctrl_t;

endpackage

// File: hdl/slist_cell.sv
// ----------------------------------------------------------------------------
// slist_cell: one storage cell of the sorted insertion list
// Holds one entry, compares it with the request value and shifts it toward
// or away from its neighbors on insert and remove.
// ----------------------------------------------------------------------------
module slist_cell
(
    input  logic                      clk,
    input  slist_pkg::cell_ctrl_t     ctrl,
    input  logic                      occupied,
    input  logic                      tail,
    input  logic                      left_ge,
    input  logic signed [31:0]        left_entry,
    input  logic signed [31:0]        right_entry,
    output logic signed [31:0]        entry,
    output logic                      ge,
    output logic                      eq
);

    logic signed [31:0] entry_reg;
    logic signed [31:0] entry_next;

    assign entry = entry_reg;
    assign ge    = occupied && (entry_reg >= ctrl.value);
    assign eq    = occupied && (entry_reg == ctrl.value);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.insert)
        begin
            if (left_ge)
            begin
                entry_next = left_entry;
            end
            else if (ge || tail)
            begin
                entry_next = ctrl.value;
            end
        end
        else if (ctrl.remove && ge)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// File: hdl/sorted_list_insert_remove.sv
// ----------------------------------------------------------------------------
// sorted_list_insert_remove: bounded sorted list of signed 32-bit values
// Keeps up to CAPACITY entries in ascending order in a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   A request (req: opcode, value, position) is taken at a rising edge where
//   start is high and busy is low. busy stays low: a new request may be
//   issued in every cycle.
//   Insert places the value before the first entry greater or equal; remove
//   deletes the first equal entry; read returns the entry at position.
//   Each request gives one result (rsp: read_value, entry_count, status)
//   in the next cycle, marked by done for exactly one cycle.
//   Throughput 1 request per cycle. Every cell compares its entry with the
//   request value in parallel and keeps its entry or loads the request value,
//   its left or its right neighbor in the same edge; the 32-bit compare per
//   cell and the count update set the cycle.
//   The result is not held: the receiver takes it in the cycle done is high.
//   Reset empties the list (count zero) and clears done. Entry contents are
//   not reset; only entries below the count are ever read.
// ----------------------------------------------------------------------------
module sorted_list_insert_remove
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  slist_pkg::req_t   req,
    output logic              done,
    output slist_pkg::rsp_t   rsp
);

    logic [slist_pkg::CNT_W-1:0] count_reg;
    logic [slist_pkg::CNT_W-1:0] count_next;
    logic                        done_reg;
    slist_pkg::rsp_t             rsp_reg;
    slist_pkg::rsp_t             rsp_next;

    slist_pkg::cell_ctrl_t       ctrl;
    logic signed [31:0]          entries [slist_pkg::CAPACITY];
    logic [slist_pkg::CAPACITY-1:0] ge_vec;
    logic [slist_pkg::CAPACITY-1:0] eq_vec;

    logic                        accept;
    logic                        full;
    logic                        any_match;
    logic                        pos_ok;
    logic signed [31:0]          tap_value;
    logic [31:0]                 count_ext;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (int'(count_reg) >= slist_pkg::CAPACITY);
    assign any_match = |eq_vec;
    assign pos_ok = (int'(req.position) < int'(count_reg));

    assign ctrl.insert = accept && (req.opcode == slist_pkg::OP_INSERT) && !full;
    assign ctrl.remove = accept && (req.opcode == slist_pkg::OP_REMOVE) && any_match;
    assign ctrl.value  = req.value;

    genvar g;
    generate
        for (g = 0; g < slist_pkg::CAPACITY; g++)
        begin : g_cell
            logic               left_ge;
            logic signed [31:0] left_entry;
            logic signed [31:0] right_entry;

            if (g == 0)
            begin : g_first
                assign left_ge    = 1'b0;
                assign left_entry = '0;
            end
            else
            begin : g_inner_l
                assign left_ge    = ge_vec[g-1];
                assign left_entry = entries[g-1];
            end

            if (g == slist_pkg::CAPACITY - 1)
            begin : g_last
                assign right_entry = '0;
            end
            else
            begin : g_inner_r
                assign right_entry = entries[g+1];
            end

            slist_cell u_cell
            (
                .clk         (clk),
                .ctrl        (ctrl),
                .occupied    (g < int'(count_reg)),
                .tail        (g == int'(count_reg)),
                .left_ge     (left_ge),
                .left_entry  (left_entry),
                .right_entry (right_entry),
                .entry       (entries[g]),
                .ge          (ge_vec[g]),
                .eq          (eq_vec[g])
            );
        end
    endgenerate

    always_comb
    begin
        tap_value = '0;
        for (int i = 0; i < slist_pkg::CAPACITY; i++)
        begin
            if (int'(req.position) == i)
            begin
                tap_value = tap_value | entries[i];
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.insert)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctrl.remove)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_comb
    begin
        count_ext           = 32'(count_next);
        rsp_next.read_value = '0;
        rsp_next.entry_count = count_ext[4:0];
        rsp_next.status     = slist_pkg::ST_OK;
        case (req.opcode)
            slist_pkg::OP_INSERT:
            begin
                if (full)
                begin
                    rsp_next.status = slist_pkg::ST_FULL;
                end
            end
            slist_pkg::OP_REMOVE:
            begin
                if (!any_match)
                begin
                    rsp_next.status = slist_pkg::ST_NO_MATCH;
                end
            end
            slist_pkg::OP_READ:
            begin
                if (pos_ok)
                begin
                    rsp_next.read_value = tap_value;
                end
                else
                begin
                    rsp_next.status = slist_pkg::ST_BAD_POS;
                end
            end
            default:
            begin
                rsp_next.status = slist_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= slist_pkg::CAPACITY)
        else $error("entry count beyond capacity");

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("request without result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> !done)
        else $error("result without request");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        done && (rsp.status == slist_pkg::ST_FULL)
        |-> int'(count_reg) == slist_pkg::CAPACITY)
        else $error("insert dropped while not full");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        done && (rsp.status != slist_pkg::ST_OK) |-> $stable(count_reg))
        else $error("count changed on failed request");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the sorted insertion list
// Drives insert, remove, read and unused-opcode requests through the
// start/busy handshake and keeps a shadow copy of the sorted store to predict
// each result. Every result marked by done is checked field by field against
// the oldest prediction. A directed pass covers the value extremes, duplicates,
// misses and reads past the count. A fill-and-drain pass reaches the full
// store, and random phases with varying sender gaps sweep the fill level.
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic [1:0] OP_NOP      = 2'd3;
    localparam int         MAX_REPORTS = 10;

    localparam logic [31:0] VALUE_POOL [8] = '{
        32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
        32'h8000_0000, 32'h0000_0005, 32'hFFFF_FFFB, 32'h0000_0064
    };

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic done;
    slist_pkg::req_t req;
    slist_pkg::rsp_t rsp;

    logic signed [31:0] list_entries [slist_pkg::CAPACITY];
    int                 list_count;
    slist_pkg::rsp_t    pending_rsp_q [$];
    slist_pkg::rsp_t    head_rsp;
    int                 fail_count;
    int                 idle_pct;

    sorted_list_insert_remove DUT
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #200000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic slist_pkg::rsp_t apply_list_op(slist_pkg::req_t r);
        slist_pkg::rsp_t res;
        int              i;
        int              k;
        res = '0;
        i   = 0;
        case (r.opcode)
            slist_pkg::OP_INSERT:
            begin
                if (list_count >= slist_pkg::CAPACITY)
                    res.status = slist_pkg::ST_FULL;
                else
                begin
                    while (i < list_count && list_entries[i] < $signed(r.value))
                        i++;
                    for (k = list_count; k > i; k--)
                        list_entries[k] = list_entries[k - 1];
                    list_entries[i] = r.value;
                    list_count++;
                end
            end
            slist_pkg::OP_REMOVE:
            begin
                while (i < list_count && list_entries[i] != r.value)
                    i++;
                if (i >= list_count)
                    res.status = slist_pkg::ST_NO_MATCH;
                else
                begin
                    for (k = i; k + 1 < list_count; k++)
                        list_entries[k] = list_entries[k + 1];
                    list_count--;
                end
            end
            slist_pkg::OP_READ:
            begin
                if (int'(r.position) < list_count)
                    res.read_value = list_entries[r.position];
                else
                    res.status = slist_pkg::ST_BAD_POS;
            end
            default:
            begin
            end
        endcase
        res.entry_count = 5'(list_count);
        return res;
    endfunction

    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2: v = VALUE_POOL[$urandom_range(0, 7)];
            3, 4:
            begin
                if (list_count > 0)
                    v = list_entries[$urandom_range(0, list_count - 1)];
                else
                    v = $urandom;
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic hold_off(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    task automatic send_req(input logic [1:0] op, input logic [31:0] val,
                            input logic [3:0] pos);
        slist_pkg::req_t r;
        r.opcode   = op;
        r.value    = val;
        r.position = pos;
        @(negedge clk);
        start <= 1'b1;
        req   <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_rsp_q.push_back(apply_list_op(r));
        if ($urandom_range(0, 99) < idle_pct)
            hold_off($urandom_range(1, 3));
    endtask

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("mismatch %s at %0t: expected %h, got %h",
                         field, $realtime, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_rsp_q.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected result at %0t: %h", $realtime, rsp);
            end
            else
            begin
                head_rsp = pending_rsp_q.pop_front();
                compare_field("read_value", head_rsp.read_value, rsp.read_value);
                compare_field("entry_count", 32'(head_rsp.entry_count),
                              32'(rsp.entry_count));
                compare_field("status", 32'(head_rsp.status), 32'(rsp.status));
            end
        end
    end

    task automatic test_directed();
        idle_pct = 0;
        send_req(slist_pkg::OP_READ,   32'h0000_0000, 4'd0);
        send_req(slist_pkg::OP_REMOVE, 32'h0000_0000, 4'd0);
        send_req(OP_NOP,               32'hFFFF_FFFF, 4'hF);
        send_req(slist_pkg::OP_INSERT, 32'h0000_0000, 4'd0);
        send_req(slist_pkg::OP_INSERT, 32'h7FFF_FFFF, 4'hF);
        send_req(slist_pkg::OP_INSERT, 32'h8000_0000, 4'd0);
        send_req(slist_pkg::OP_INSERT, 32'hFFFF_FFFF, 4'd0);
        send_req(slist_pkg::OP_INSERT, 32'h0000_0000, 4'd0);
        send_req(slist_pkg::OP_READ,   32'hFFFF_FFFF, 4'd0);
        send_req(slist_pkg::OP_READ,   32'h0000_0000, 4'd1);
        send_req(slist_pkg::OP_READ,   32'h0000_0000, 4'd2);
        send_req(slist_pkg::OP_READ,   32'h0000_0000, 4'd3);
        send_req(slist_pkg::OP_READ,   32'h0000_0000, 4'd4);
        send_req(slist_pkg::OP_READ,   32'h0000_0000, 4'd5);
        send_req(slist_pkg::OP_READ,   32'h0000_0000, 4'hF);
        send_req(slist_pkg::OP_REMOVE, 32'h0000_0000, 4'd0);
        send_req(slist_pkg::OP_REMOVE, 32'h0000_3039, 4'd0);
        send_req(slist_pkg::OP_REMOVE, 32'h8000_0000, 4'd0);
        send_req(slist_pkg::OP_REMOVE, 32'h7FFF_FFFF, 4'd0);
        send_req(slist_pkg::OP_READ,   32'h0000_0000, 4'd0);
        send_req(slist_pkg::OP_READ,   32'h0000_0000, 4'd1);
        send_req(OP_NOP,               32'h0000_0000, 4'd0);
    endtask

    task automatic test_fill_and_drain();
        int n;
        idle_pct = 45;
        while (list_count < slist_pkg::CAPACITY)
            send_req(slist_pkg::OP_INSERT, pick_value(), 4'($urandom));
        send_req(slist_pkg::OP_INSERT, pick_value(), 4'd0);
        send_req(slist_pkg::OP_INSERT, 32'h8000_0000, 4'd0);
        for (n = 0; n < slist_pkg::CAPACITY; n++)
            send_req(slist_pkg::OP_READ, $urandom, 4'(n));
        send_req(OP_NOP, $urandom, 4'($urandom));
        while (list_count > 0)
            send_req(slist_pkg::OP_REMOVE,
                     list_entries[$urandom_range(0, list_count - 1)],
                     4'($urandom));
        send_req(slist_pkg::OP_REMOVE, pick_value(), 4'd0);
    endtask

    task automatic run_random(input int items, input int pct, input int insert_weight);
        int          n;
        int          roll;
        logic [31:0] val;
        logic [3:0]  pos;
        idle_pct = pct;
        for (n = 0; n < items; n++)
        begin
            roll = $urandom_range(0, 99);
            val  = $urandom;
            pos  = 4'($urandom);
            if (roll < 4)
                send_req(OP_NOP, val, pos);
            else if (roll < 30)
            begin
                if (list_count > 0 && $urandom_range(0, 1))
                    pos = 4'($urandom_range(0, list_count - 1));
                send_req(slist_pkg::OP_READ, val, pos);
            end
            else if (roll < 30 + insert_weight)
                send_req(slist_pkg::OP_INSERT, pick_value(), pos);
            else
            begin
                if (list_count > 0 && $urandom_range(0, 3) != 0)
                    val = list_entries[$urandom_range(0, list_count - 1)];
                else
                    val = pick_value();
                send_req(slist_pkg::OP_REMOVE, val, pos);
            end
        end
    endtask

    task automatic test_random_mix();
        run_random(125, 0, 35);
        run_random(125, 45, 50);
        run_random(125, 0, 20);
        run_random(125, 9, 42);
    endtask

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        req        = '0;
        idle_pct   = 0;
        fail_count = 0;
        list_count = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_fill_and_drain();
        test_random_mix();
        @(negedge clk);
        start <= 1'b0;
        while (pending_rsp_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: filelist.f
hdl/slist_pkg.sv
hdl/slist_cell.sv
hdl/sorted_list_insert_remove.sv
tb/tb_top.sv
